[rtl/core/plte_pkg.sv]
// Shared constants and codes for the piecewise linear table evaluator.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package plte_pkg;

  localparam int DATA_W         = 32;
  localparam int FRAC_W         = 16;
  localparam int COUNT_W        = 5;
  localparam int INDEX_W        = 4;
  localparam int STATUS_W       = 2;
  localparam int MAX_POINTS_DEF = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_RANGE = 2'd2,
    ST_ORDER = 2'd3
  } plte_status_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EVAL = 1'b1
  } plte_action_t;

endpackage

`default_nettype wire

[rtl/core/plte_ifs.sv]
// Valid/ready channel interfaces: request items, results and the count register write.
// Depends on plte_pkg for field widths.
`default_nettype none

interface plte_item_if import plte_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [INDEX_W-1:0]  entry_index;
  logic [DATA_W-1:0]   point_time;
  logic signed [DATA_W-1:0] point_value;
  logic [DATA_W-1:0]   query_time;

  modport source (output valid, action, entry_index, point_time, point_value, query_time,
                  input ready);
  modport sink   (input valid, action, entry_index, point_time, point_value, query_time,
                  output ready);
endinterface

interface plte_result_if import plte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

interface plte_cfg_if import plte_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/core/piecewise_linear_table_eval.sv]
// Piecewise linear table evaluator: breakpoint store, binary search, serial divide, interpolate.
// Load: the previous point is read and checked for order. Evaluate: too few points give ST_FEW,
// queries at or below the first point or at or above the last return that point's value, else
// a binary search on the registered table read and 16 shared-subtractor divide steps follow.
// One request at a time; ready is low while a request is in work or its result waits for the output register.
// Reset (rst, synchronous) clears the sequencer, point count and output valid, not the store.
`default_nettype none

module piecewise_linear_table_eval import plte_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  plte_item_if.sink      item,
  plte_result_if.source  result,
  plte_cfg_if.sink       cfg
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(FRAC_W);
  localparam int SUB_W  = DATA_W + 1;
  localparam int PROD_W = SUB_W + FRAC_W + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_RD, S_LD_CHK, S_EV0_RD, S_EV0_CHK, S_EVN_RD, S_EVN_CHK,
    S_SRCH_RD, S_SRCH_CMP, S_PICK, S_PL_RD, S_PL_CHK, S_PR_RD, S_PR_CHK,
    S_DEN, S_DIV, S_VDIFF, S_MUL, S_ACC, S_FINISH
  } state_t;

  state_t state;

  logic [COUNT_W-1:0] point_count;
  logic [INDEX_W-1:0] idx;
  logic [DATA_W-1:0]  ptime;
  logic [DATA_W-1:0]  pval;
  logic [DATA_W-1:0]  q;
  logic [COUNT_W-1:0] lo;
  logic [COUNT_W-1:0] len;
  logic [COUNT_W-1:0] right;
  logic [DATA_W-1:0]  tl;
  logic [DATA_W-1:0]  den;
  logic [DATA_W-1:0]  rem;
  logic [DATA_W-1:0]  vl;
  logic [DATA_W-1:0]  vr;
  logic [FRAC_W-1:0]  f;
  logic [CNT_W-1:0]   cnt;
  logic [SUB_W-1:0]   dv;
  logic signed [PROD_W-1:0] prod;
  logic [DATA_W-1:0]  res_value;
  plte_status_t       res_status;
  logic [DATA_W-1:0]  out_value;
  plte_status_t       out_status;
  logic               out_valid;

  logic [DATA_W-1:0]  times_mem  [MAX_POINTS];
  logic [DATA_W-1:0]  values_mem [MAX_POINTS];
  logic [DATA_W-1:0]  rd_time;
  logic [DATA_W-1:0]  rd_value;

  logic [COUNT_W-1:0] n_eff;
  logic [COUNT_W-1:0] half;
  logic [COUNT_W-1:0] mid;
  logic [AW-1:0]      rd_addr;
  logic               in_range;
  logic               load_ok;
  logic [SUB_W-1:0]   sub_a;
  logic [SUB_W-1:0]   sub_b;
  logic [SUB_W:0]     diff;
  logic               borrow;
  logic               zero;
  logic [PROD_W-1:0]  acc_sum;

  assign n_eff = (int'(point_count) > MAX_POINTS) ? COUNT_W'(MAX_POINTS) : point_count;
  assign half  = len >> 1;
  assign mid   = lo + half;

  assign in_range = {1'b0, idx} < n_eff;
  assign load_ok  = in_range && !((idx != '0) && (borrow || zero));

  // shared subtractor: compares, bracket width, divide steps, value difference
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state)
      S_LD_CHK: begin
        sub_a = {1'b0, ptime};
        sub_b = {1'b0, rd_time};
      end
      S_EV0_CHK, S_EVN_CHK, S_SRCH_CMP, S_PL_CHK, S_PR_CHK: begin
        sub_a = {1'b0, q};
        sub_b = {1'b0, rd_time};
      end
      S_DEN: begin
        sub_a = {1'b0, den};
        sub_b = {1'b0, tl};
      end
      S_DIV: begin
        sub_a = {rem, 1'b0};
        sub_b = {1'b0, den};
      end
      S_VDIFF: begin
        sub_a = {vr[DATA_W-1], vr};
        sub_b = {vl[DATA_W-1], vl};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow  = diff[SUB_W];
  assign zero    = (diff[SUB_W-1:0] == '0);
  assign acc_sum = {{(PROD_W-DATA_W-FRAC_W){vl[DATA_W-1]}}, vl, FRAC_W'(0)} + prod;

  always_comb begin
    case (state)
      S_LD_RD:   rd_addr = AW'(COUNT_W'(idx) - COUNT_W'(1));
      S_EV0_RD:  rd_addr = '0;
      S_EVN_RD:  rd_addr = AW'(n_eff - COUNT_W'(1));
      S_SRCH_RD: rd_addr = AW'(mid);
      S_PL_RD:   rd_addr = AW'(right - COUNT_W'(1));
      S_PR_RD:   rd_addr = AW'(right);
      default:   rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_LD_CHK && load_ok) begin
      times_mem[AW'(idx)]  <= ptime;
      values_mem[AW'(idx)] <= pval;
    end
    rd_time  <= times_mem[rd_addr];
    rd_value <= values_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        point_count <= cfg.data;
      end
      if (state == S_FINISH && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            idx        <= item.entry_index;
            ptime      <= item.point_time;
            pval       <= item.point_value;
            q          <= item.query_time;
            res_value  <= '0;
            res_status <= ST_OK;
            if (item.action == ACT_LOAD) begin
              state <= S_LD_RD;
            end else if (n_eff < COUNT_W'(2)) begin
              res_status <= ST_FEW;
              state      <= S_FINISH;
            end else begin
              state <= S_EV0_RD;
            end
          end
        end
        S_LD_RD: state <= S_LD_CHK;
        S_LD_CHK: begin
          if (!in_range) begin
            res_status <= ST_RANGE;
          end else if (!load_ok) begin
            res_status <= ST_ORDER;
          end
          state <= S_FINISH;
        end
        S_EV0_RD: state <= S_EV0_CHK;
        S_EV0_CHK: begin
          if (borrow || zero) begin
            res_value <= rd_value;
            state     <= S_FINISH;
          end else begin
            state <= S_EVN_RD;
          end
        end
        S_EVN_RD: state <= S_EVN_CHK;
        S_EVN_CHK: begin
          if (!borrow) begin
            res_value <= rd_value;
            state     <= S_FINISH;
          end else begin
            lo    <= '0;
            len   <= n_eff;
            state <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          state <= (len == '0) ? S_PICK : S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (!borrow) begin
            lo  <= mid + COUNT_W'(1);
            len <= len - half - COUNT_W'(1);
          end else begin
            len <= half;
          end
          state <= S_SRCH_RD;
        end
        S_PICK: begin
          if (lo == '0) begin
            right <= COUNT_W'(1);
          end else if (lo > n_eff - COUNT_W'(1)) begin
            right <= n_eff - COUNT_W'(1);
          end else begin
            right <= lo;
          end
          state <= S_PL_RD;
        end
        S_PL_RD: state <= S_PL_CHK;
        S_PL_CHK: begin
          tl  <= rd_time;
          vl  <= rd_value;
          rem <= diff[DATA_W-1:0];
          if (borrow) begin
            res_value <= rd_value;
            state     <= S_FINISH;
          end else begin
            state <= S_PR_RD;
          end
        end
        S_PR_RD: state <= S_PR_CHK;
        S_PR_CHK: begin
          den <= rd_time;
          vr  <= rd_value;
          if (!borrow) begin
            res_value <= vl;
            state     <= S_FINISH;
          end else begin
            state <= S_DEN;
          end
        end
        S_DEN: begin
          den   <= diff[DATA_W-1:0];
          f     <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!borrow) begin
            rem <= diff[DATA_W-1:0];
            f   <= {f[FRAC_W-2:0], 1'b1};
          end else begin
            rem <= {rem[DATA_W-2:0], 1'b0};
            f   <= {f[FRAC_W-2:0], 1'b0};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(FRAC_W - 1)) begin
            state <= S_VDIFF;
          end
        end
        S_VDIFF: begin
          dv    <= diff[SUB_W-1:0];
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= $signed(dv) * $signed({1'b0, f});
          state <= S_ACC;
        end
        S_ACC: begin
          res_value <= acc_sum[FRAC_W +: DATA_W];
          state     <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || result.ready) begin
            out_value  <= res_value;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item.ready          = (state == S_IDLE);
  assign cfg.ready           = 1'b1;
  assign result.valid        = out_valid;
  assign result.result_value = out_value;
  assign result.status       = out_status;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> state != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < den)
    else $error("divider remainder not below divisor");

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SRCH_RD |-> ({1'b0, lo} + {1'b0, len}) <= {1'b0, n_eff})
    else $error("search window beyond point count");

  a_pair_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_PR_RD |-> right != '0 && right < n_eff)
    else $error("bracketing pair out of table");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_value == '0)
    else $error("nonzero value on failed request");

endmodule

`default_nettype wire

[test/piecewise_linear_table_eval_tb.sv]
// Testbench for piecewise_linear_table_eval: loads breakpoint tables, evaluates queries and
// checks every result against a predictor kept in the bench. Uses plte_pkg and the channel
// interfaces in plte_ifs.sv.
`default_nettype none

module piecewise_linear_table_eval_tb;
  import plte_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    plte_action_t             action;
    logic [INDEX_W-1:0]       index;
    logic [DATA_W-1:0]        ptime;
    logic signed [DATA_W-1:0] pvalue;
    logic [DATA_W-1:0]        qtime;
  } table_req_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    plte_status_t             status;
  } eval_result_t;

  logic clk = 1'b0;
  logic rst;

  plte_item_if   item_ch ();
  plte_result_if res_ch ();
  plte_cfg_if    cfg_ch ();

  piecewise_linear_table_eval i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // bench copy of the breakpoint table and the count register
  logic [DATA_W-1:0]        bp_time   [MAX_POINTS_DEF];
  logic signed [DATA_W-1:0] bp_value  [MAX_POINTS_DEF];
  bit                       bp_loaded [MAX_POINTS_DEF];
  logic [COUNT_W-1:0]       table_count;

  eval_result_t pending_results[$];
  int unsigned  mismatch_count;
  int unsigned  burst_left;
  int unsigned  stall_left;
  int unsigned  stall_mode;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned eff_points();
    return (table_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : table_count;
  endfunction

  function automatic bit load_allowed(input int unsigned idx);
    return idx >= eff_points() || idx == 0 || bp_loaded[idx-1];
  endfunction

  function automatic bit eval_allowed();
    int unsigned n;
    n = eff_points();
    if (n < 2) return 1'b1;
    for (int i = 0; i < n; i++)
      if (!bp_loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [DATA_W-1:0] interpolate_at(input int unsigned n,
                                                              input logic [DATA_W-1:0] q);
    int unsigned lo, span, half, mid, r, l;
    logic [63:0] num, quo;
    longint frac, acc;
    if (q <= bp_time[0]) return bp_value[0];
    if (q >= bp_time[n-1]) return bp_value[n-1];
    lo = 0;
    span = n;
    while (span > 0) begin
      half = span / 2;
      mid = lo + half;
      if (bp_time[mid] <= q) begin
        lo = mid + 1;
        span = span - half - 1;
      end else begin
        span = half;
      end
    end
    r = (lo < 1) ? 1 : lo;
    if (r > n - 1) r = n - 1;
    l = r - 1;
    if (!(bp_time[l] <= q && q < bp_time[r])) return bp_value[l];
    num = {16'h0, q - bp_time[l], 16'h0};
    quo = num / {32'h0, bp_time[r] - bp_time[l]};
    frac = (quo > 64'd65535) ? 65535 : longint'(quo);
    acc = (65536 - frac) * longint'(bp_value[l]) + frac * longint'(bp_value[r]);
    return DATA_W'(acc >>> FRAC_W);
  endfunction

  function automatic eval_result_t apply_table_request(input table_req_t req);
    eval_result_t r;
    int unsigned n;
    n = eff_points();
    r.value = '0;
    r.status = ST_OK;
    if (req.action == ACT_LOAD) begin
      if (req.index >= n) begin
        r.status = ST_RANGE;
      end else if (req.index > 0 && req.ptime <= bp_time[int'(req.index) - 1]) begin
        r.status = ST_ORDER;
      end else begin
        bp_time[req.index] = req.ptime;
        bp_value[req.index] = req.pvalue;
        bp_loaded[req.index] = 1'b1;
      end
    end else if (n < 2) begin
      r.status = ST_FEW;
    end else begin
      r.value = interpolate_at(n, req.qtime);
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_point_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_query(input int unsigned n);
    int unsigned k;
    if (n < 2) return $urandom;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return bp_time[k];
      3: return bp_time[k] + 1;
      4: return bp_time[k] - 1;
      5: return $urandom;
      default: return $urandom_range(bp_time[n-1], bp_time[0]);
    endcase
  endfunction

  // sender: bursts of requests separated by random gaps
  task automatic send_request(input table_req_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        item_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    item_ch.action      = req.action;
    item_ch.entry_index = req.index;
    item_ch.point_time  = req.ptime;
    item_ch.point_value = req.pvalue;
    item_ch.query_time  = req.qtime;
    item_ch.valid       = 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    pending_results.push_back(apply_table_request(req));
  endtask

  task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] t,
                           input logic signed [DATA_W-1:0] v);
    table_req_t req;
    req.action = ACT_LOAD;
    req.index  = idx;
    req.ptime  = t;
    req.pvalue = v;
    req.qtime  = $urandom;
    send_request(req);
  endtask

  task automatic send_eval(input logic [DATA_W-1:0] q);
    table_req_t req;
    req.action = ACT_EVAL;
    req.index  = INDEX_W'($urandom_range(0, 15));
    req.ptime  = $urandom;
    req.pvalue = $urandom;
    req.qtime  = q;
    send_request(req);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_point_count(input logic [COUNT_W-1:0] count);
    wait_idle();
    cfg_ch.data  = count;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    table_count = count;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic test_few_points();
    write_point_count(0);
    send_eval($urandom);
    send_load(0, 32'd100, 32'sd1);
    write_point_count(1);
    send_load(0, 32'd5, 32'sh0001_0000);
    send_eval(32'h10);
    send_load(1, 32'd20, 32'sd3);
  endtask

  task automatic test_table_ends();
    write_point_count(3);
    send_load(1, 32'd5, 32'sd7);
    send_load(1, 32'd4, 32'sd7);
    send_load(0, 32'd0, -32'sd1);
    send_load(1, 32'h8000_0000, 32'sh7FFF_FFFF);
    send_load(2, 32'hFFFF_FFFF, 32'sh8000_0000);
    send_load(3, 32'h1234_5678, 32'sd9);
    send_eval(32'h0000_0000);
    send_eval(32'h0000_0001);
    send_eval(32'h4000_0000);
    send_eval(32'h8000_0000);
    send_eval(32'hC000_0000);
    send_eval(32'hFFFF_FFFE);
    send_eval(32'hFFFF_FFFF);
  endtask

  task automatic test_unordered_table();
    send_load(0, 32'hF000_0000, 32'sh0123_4567);
    send_eval(32'h9000_0000);
    send_eval(32'hF800_0000);
  endtask

  task automatic run_table_phase(input logic [COUNT_W-1:0] count, input int unsigned n_items);
    int unsigned n, idx, kind, lim, step_max;
    logic [DATA_W-1:0] t, lo_t, hi_t;
    bit sent;
    write_point_count(count);
    n = eff_points();
    // fresh ascending table with random spacing
    t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 32'h00FF_FFFF);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        step_max = (32'hFFFF_FFFF - t) / (n - i);
        case ($urandom_range(0, 3))
          0: lim = 4;
          1: lim = 32'h0004_0000;
          2: lim = 32'h0100_0000;
          default: lim = 32'hFFFF_FFFF;
        endcase
        t = t + $urandom_range(1, (lim < step_max) ? lim : step_max);
      end
      send_load(INDEX_W'(i), t, rand_point_value());
    end
    for (int k = 0; k < n_items; k++) begin
      kind = $urandom_range(0, 99);
      sent = 1'b0;
      if (kind < 55) begin
        if (eval_allowed()) begin
          send_eval(rand_query(n));
          sent = 1'b1;
        end
      end else if (kind < 70) begin
        // rewrite a slot, keeping it between its neighbors when possible
        if (n > 0) begin
          idx = $urandom_range(0, n - 1);
          if (load_allowed(idx) && !(idx > 0 && bp_time[idx-1] == '1)) begin
            lo_t = (idx > 0) ? bp_time[idx-1] + 1 : '0;
            hi_t = (idx + 1 < n && bp_loaded[idx+1] && bp_time[idx+1] != 0) ?
                   bp_time[idx+1] - 1 : '1;
            t = (lo_t <= hi_t) ? $urandom_range(hi_t, lo_t) : $urandom;
            send_load(INDEX_W'(idx), t, rand_point_value());
            sent = 1'b1;
          end
        end
      end else if (kind < 80) begin
        if (n >= 2) begin
          idx = $urandom_range(1, n - 1);
          if (load_allowed(idx)) begin
            t = ($urandom_range(0, 1) == 0) ? bp_time[idx-1] : $urandom_range(bp_time[idx-1], 0);
            send_load(INDEX_W'(idx), t, rand_point_value());
            sent = 1'b1;
          end
        end
      end else if (kind < 88) begin
        if (n < MAX_POINTS_DEF) begin
          send_load(INDEX_W'($urandom_range(n, 15)), $urandom, rand_point_value());
          sent = 1'b1;
        end
      end else begin
        idx = $urandom_range(0, 15);
        if (load_allowed(idx)) begin
          send_load(INDEX_W'(idx), $urandom, rand_point_value());
          sent = 1'b1;
        end
      end
      if (!sent) send_load(0, $urandom, rand_point_value());
    end
  endtask

  task automatic test_random_tables();
    run_table_phase(16, 110);
    run_table_phase(2, 110);
    run_table_phase(31, 110);
    run_table_phase(0, 110);
    run_table_phase(5, 110);
    run_table_phase(1, 110);
    run_table_phase(16, 110);
    run_table_phase(3, 110);
    run_table_phase(20, 110);
    run_table_phase(9, 110);
    run_table_phase(13, 110);
    run_table_phase(16, 110);
  endtask

  // receiver stall pattern: modes of random length
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(16, 96);
      stall_mode = $urandom_range(0, 3);
    end
    stall_left = stall_left - 1;
    case (stall_mode)
      0: res_ch.ready = 1'b1;
      1: res_ch.ready = ($urandom_range(0, 3) != 0);
      2: res_ch.ready = ($urandom_range(0, 7) == 0);
      default: res_ch.ready = ~res_ch.ready;
    endcase
  end

  always @(posedge clk) begin
    eval_result_t exp_res;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: result_value %0d status %0d",
               res_ch.result_value, res_ch.status);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (res_ch.result_value !== exp_res.value) begin
          $error("result_value: expected %0d, got %0d", exp_res.value, res_ch.result_value);
          mismatch_count++;
        end
        if (res_ch.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, res_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.action      = ACT_LOAD;
    item_ch.entry_index = '0;
    item_ch.point_time  = '0;
    item_ch.point_value = '0;
    item_ch.query_time  = '0;
    res_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    table_count         = '0;
    mismatch_count      = 0;
    burst_left          = 0;
    stall_left          = 0;
    stall_mode          = 0;
    for (int i = 0; i < MAX_POINTS_DEF; i++) begin
      bp_time[i]   = '0;
      bp_value[i]  = '0;
      bp_loaded[i] = 1'b0;
    end
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_few_points();
    test_table_ends();
    test_unordered_table();
    test_random_tables();

    wait_idle();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
